### rtl/pgp_marker_scanner_assert.svh
// ----------------------------------------------------------------------------
// pgp marker scanner assertion macros
// clocked property wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef PGP_MARKER_SCANNER_ASSERT_SVH
`define PGP_MARKER_SCANNER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgp marker scanner: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgp marker scanner: next-cycle check failed");

`endif

### rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// widths, marker strings and shared types of the pgp marker scanner
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned FlagW       = 4;
  localparam int unsigned CountW      = 3;
  localparam int unsigned MinW        = 3;
  localparam int unsigned WindowDepth = 28;
  localparam int unsigned MarkerNum   = 4;
  localparam int unsigned MarkerMax   = 29;

  localparam logic [MinW-1:0] MinPointsReset = MinW'(2);

  // markers stored lower case, last character in the low byte
  typedef logic [MarkerMax*ByteW-1:0] psm_marker_t;

  localparam psm_marker_t MarkerText [MarkerNum] = '{
    psm_marker_t'("application/pgp-encrypted"),
    psm_marker_t'("application/pgp-signature"),
    psm_marker_t'("-----begin pgp signature-----"),
    psm_marker_t'("-----begin pgp message-----")
  };

  localparam int unsigned MarkerLen [MarkerNum] = '{25, 25, 29, 27};

  // one queued item from the front to the back
  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             scan;
    logic             last_byte;
  } psm_entry_t;

  // queue slot with its valid flag
  typedef struct packed {
    logic       valid;
    psm_entry_t entry;
  } psm_slot_t;

  // ascii upper to lower, everything else unchanged
  function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= ByteW'("A") && c <= ByteW'("Z")) begin
      r = c + ByteW'(32);
    end
    return r;
  endfunction

endpackage

### rtl/psm_in_if.sv
// ----------------------------------------------------------------------------
// psm_in_if
// byte input channel of the pgp marker scanner
// ----------------------------------------------------------------------------
interface psm_in_if
  import psm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

### rtl/psm_out_if.sv
// ----------------------------------------------------------------------------
// psm_out_if
// result channel of the pgp marker scanner
// ----------------------------------------------------------------------------
interface psm_out_if
  import psm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              is_pgp;
  logic [FlagW-1:0]  marker_flags;
  logic [CountW-1:0] marker_count;

  modport source (output valid, is_pgp, marker_flags, marker_count, input ready);
  modport sink   (input valid, is_pgp, marker_flags, marker_count, output ready);
endinterface

### rtl/psm_cfg_if.sv
// ----------------------------------------------------------------------------
// psm_cfg_if
// threshold register write channel of the pgp marker scanner
// ----------------------------------------------------------------------------
interface psm_cfg_if
  import psm_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [MinW-1:0] min_points;

  modport source (output valid, min_points, input ready);
  modport sink   (input valid, min_points, output ready);
endinterface

### rtl/psm_front.sv
// ----------------------------------------------------------------------------
// psm_front
// accepts bytes, folds case, tracks end of text and drops ignored bytes
// ----------------------------------------------------------------------------
module psm_front
  import psm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  psm_in_if.sink    item_i,
  input  logic      full_i,
  output psm_slot_t push_o
);

  logic text_ended_q, text_ended_d;
  logic accept;
  logic is_zero;

  assign item_i.ready = !full_i;
  assign accept       = item_i.valid && item_i.ready;
  assign is_zero      = (item_i.text_byte == '0);

  // classify: bytes after end of text only matter if they close the message
  always_comb begin
    push_o.entry.text_byte = fold_case(item_i.text_byte);
    push_o.entry.scan      = !text_ended_q && !is_zero;
    push_o.entry.last_byte = item_i.last_byte;
    push_o.valid           = accept && (push_o.entry.scan || item_i.last_byte);
  end

  // end of text flag, cleared with each message
  always_comb begin
    text_ended_d = text_ended_q;
    if (accept) begin
      if (item_i.last_byte) begin
        text_ended_d = 1'b0;
      end else if (is_zero) begin
        text_ended_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_ended_q <= 1'b0;
    end else begin
      text_ended_q <= text_ended_d;
    end
  end

endmodule

### rtl/psm_queue.sv
// ----------------------------------------------------------------------------
// psm_queue
// short fifo between the classifying front and the matching back
// ----------------------------------------------------------------------------
module psm_queue
  import psm_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  psm_slot_t push_i,
  output logic      full_o,
  output psm_slot_t head_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  psm_entry_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

### rtl/psm_back.sv
// ----------------------------------------------------------------------------
// psm_back
// byte window, parallel marker compare, sticky flags and result register
// ----------------------------------------------------------------------------
module psm_back
  import psm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  psm_slot_t head_i,
  output logic      pop_o,
  psm_cfg_if.sink   cfg_i,
  psm_out_if.source result_o
);

  logic [ByteW-1:0]  window_q [WindowDepth];
  logic [ByteW-1:0]  hist [MarkerMax];
  logic [FlagW-1:0]  match;
  logic [FlagW-1:0]  seen_q, seen_d;
  logic [CountW-1:0] count;
  logic [MinW-1:0]   min_points_q;
  logic              out_valid_q;
  logic              is_pgp_q;
  logic [FlagW-1:0]  flags_q;
  logic [CountW-1:0] count_q;
  psm_entry_t        head;

  assign head = head_i.entry;

  // threshold register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_points_q <= MinPointsReset;
    end else if (cfg_i.valid) begin
      min_points_q <= cfg_i.min_points;
    end
  end

  // current byte plus window, newest first
  always_comb begin
    hist[0] = head.text_byte;
    for (int k = 1; k < MarkerMax; k++) begin
      hist[k] = window_q[k-1];
    end
  end

  // compare every marker ending at the current byte
  always_comb begin
    for (int m = 0; m < MarkerNum; m++) begin
      match[m] = 1'b1;
      for (int k = 0; k < MarkerMax; k++) begin
        if (k < MarkerLen[m] && hist[k] != MarkerText[m][ByteW*k +: ByteW]) begin
          match[m] = 1'b0;
        end
      end
    end
  end

  // flags and count after this item
  always_comb begin
    seen_d = head.scan ? (seen_q | match) : seen_q;
    count  = '0;
    for (int m = 0; m < MarkerNum; m++) begin
      count = count + CountW'(seen_d[m]);
    end
  end

  // a closing item needs the result register free
  assign pop_o = head_i.valid && (!head.last_byte || !out_valid_q || result_o.ready);

  // window and sticky flags, cleared at message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WindowDepth; k++) begin
        window_q[k] <= '0;
      end
      seen_q <= '0;
    end else if (pop_o) begin
      if (head.last_byte) begin
        for (int k = 0; k < WindowDepth; k++) begin
          window_q[k] <= '0;
        end
        seen_q <= '0;
      end else begin
        if (head.scan) begin
          window_q[0] <= head.text_byte;
          for (int k = 1; k < WindowDepth; k++) begin
            window_q[k] <= window_q[k-1];
          end
        end
        seen_q <= seen_d;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && head.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && head.last_byte) begin
      is_pgp_q <= (count >= CountW'(min_points_q));
      flags_q  <= seen_d;
      count_q  <= count;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.is_pgp       = is_pgp_q;
  assign result_o.marker_flags = flags_q;
  assign result_o.marker_count = count_q;

endmodule

### rtl/pgp_marker_scanner.sv
// ----------------------------------------------------------------------------
// pgp_marker_scanner: case-insensitive search for four pgp markers
// throughput one byte per cycle, one queue pop per cycle in the back, unless
// a last byte waits on a busy result; result valid registered behind the queue
// async active-low reset clears window, flags, queue and sets min_points to 2
// ----------------------------------------------------------------------------
module pgp_marker_scanner
  import psm_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psm_in_if.sink    item_i,
  psm_cfg_if.sink   cfg_i,
  psm_out_if.source result_o
);

  psm_slot_t push;
  psm_slot_t head;
  logic      full;
  logic      pop;

  // accept and classify
  psm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .full_i (full),
    .push_o (push)
  );

  // decoupling queue
  psm_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // match and report
  psm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .cfg_i    (cfg_i),
    .result_o (result_o)
  );

endmodule

### rtl/psm_checker.sv
// ----------------------------------------------------------------------------
// psm_checker
// port level checks of the pgp marker scanner results
// ----------------------------------------------------------------------------
`include "pgp_marker_scanner_assert.svh"

module psm_checker
  import psm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [MinW-1:0]   cfg_min_points,
  input logic              out_valid,
  input logic              out_ready,
  input logic              is_pgp,
  input logic [FlagW-1:0]  marker_flags,
  input logic [CountW-1:0] marker_count
);

  logic [MinW-1:0] min_q;

  // shadow of the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinPointsReset;
    end else if (cfg_valid && cfg_ready) begin
      min_q <= cfg_min_points;
    end
  end

  // a stalled result stays offered
  `PSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `PSM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({is_pgp, marker_flags, marker_count}))

  // count agrees with the flags
  `PSM_ASSERT_NOW(a_count_flags, out_valid, marker_count == CountW'($countones(marker_flags)))

  // verdict follows count and threshold
  `PSM_ASSERT_NOW(a_verdict, out_valid, is_pgp == (marker_count >= CountW'(min_q)))

endmodule

bind pgp_marker_scanner psm_checker u_psm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid      (cfg_i.valid),
  .cfg_ready      (cfg_i.ready),
  .cfg_min_points (cfg_i.min_points),
  .out_valid      (result_o.valid),
  .out_ready      (result_o.ready),
  .is_pgp         (result_o.is_pgp),
  .marker_flags   (result_o.marker_flags),
  .marker_count   (result_o.marker_count)
);

### verif/tb_pgp_marker_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pgp_marker_scanner
// Sends messages with whole, broken and mixed-case pgp markers through the
// scanner, together with noise and zero bytes. A scoreboard class keeps its
// own window, flags and threshold and checks every verdict.
// ----------------------------------------------------------------------------
module tb_pgp_marker_scanner;
  import psm_pkg::*;

  localparam int StallLimit = 3000;
  localparam int PhaseItems = 115;

  typedef struct packed {
    logic              is_pgp;
    logic [FlagW-1:0]  marker_flags;
    logic [CountW-1:0] marker_count;
  } verdict_t;

  // tracks scan state and the verdicts still owed by the block
  class verdict_board;
    logic [ByteW-1:0]  history [WindowDepth];
    logic [FlagW-1:0]  found;
    bit                ended;
    logic [MinW-1:0]   threshold;
    verdict_t          awaited [$];
    int unsigned       errors;

    function new();
      clear();
      threshold = MinPointsReset;
      errors    = 0;
    endfunction

    static function string marker_text(int m);
      case (m)
        0:       return "application/pgp-encrypted";
        1:       return "application/pgp-signature";
        2:       return "-----BEGIN PGP SIGNATURE-----";
        default: return "-----BEGIN PGP MESSAGE-----";
      endcase
    endfunction

    static function logic [ByteW-1:0] lower(logic [ByteW-1:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
    endfunction

    function void clear();
      foreach (history[i]) history[i] = '0;
      found = '0;
      ended = 1'b0;
    endfunction

    // does marker m end with the byte just arriving
    function bit marker_at(int m, logic [ByteW-1:0] cur);
      string s;
      int n;
      logic [ByteW-1:0] c;
      s = marker_text(m);
      n = s.len();
      for (int k = 0; k < n; k++) begin
        c = (k == 0) ? cur : history[k-1];
        if (lower(c) != lower(8'(s[n-1-k]))) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [ByteW-1:0] b, logic last);
      int cnt;
      if (!ended) begin
        if (b == '0) begin
          ended = 1'b1;
        end else begin
          for (int m = 0; m < MarkerNum; m++) begin
            if (marker_at(m, b)) found[m] = 1'b1;
          end
          for (int i = WindowDepth - 1; i > 0; i--) history[i] = history[i-1];
          history[0] = b;
        end
      end
      if (last) begin
        cnt = 0;
        for (int m = 0; m < MarkerNum; m++) cnt += found[m];
        awaited.push_back('{is_pgp: (cnt >= threshold), marker_flags: found,
                            marker_count: CountW'(cnt)});
        clear();
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (awaited.size() == 0) begin
        $error("verdict arrived with no message pending");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.is_pgp !== want.is_pgp) begin
        $error("is_pgp: expected %0d, got %0d", want.is_pgp, got.is_pgp);
        errors++;
      end
      if (got.marker_flags !== want.marker_flags) begin
        $error("marker_flags: expected %b, got %b", want.marker_flags, got.marker_flags);
        errors++;
      end
      if (got.marker_count !== want.marker_count) begin
        $error("marker_count: expected %0d, got %0d", want.marker_count, got.marker_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   snd_idle;
  int   rcv_idle;
  int   hold_span;
  int   quiet_cycles;
  verdict_board board;

  psm_in_if  item_if ();
  psm_cfg_if cfg_if ();
  psm_out_if res_if ();

  pgp_marker_scanner DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side ready, with random stalls and the long hold-off
  initial begin
    int left;
    left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_span != 0) begin
        left      = hold_span;
        hold_span = 0;
      end
      if (left > 0) begin
        left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // verdict check
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      board.check_verdict('{is_pgp: res_if.is_pgp, marker_flags: res_if.marker_flags,
                            marker_count: res_if.marker_count});
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one byte, entered and left at a falling edge
  task automatic send_byte(logic [ByteW-1:0] b, logic last);
    while ($urandom_range(99) < snd_idle) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid     <= 1'b1;
    item_if.text_byte <= b;
    item_if.last_byte <= last;
    do @(posedge clk); while (!item_if.ready);
    board.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_message(logic [ByteW-1:0] msg [$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // stop sending and let every owed verdict come out
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_threshold(logic [MinW-1:0] v);
    cfg_if.valid      <= 1'b1;
    cfg_if.min_points <= v;
    do @(posedge clk); while (!cfg_if.ready);
    board.threshold = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // message of markers, broken markers, filler and zero bytes, or pure noise
  function automatic void compose_message(ref logic [ByteW-1:0] msg [$]);
    int sel;
    int n;
    int bad;
    string s;
    logic [ByteW-1:0] c;
    msg.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 12)) msg.push_back(ByteW'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        s   = verdict_board::marker_text($urandom_range(MarkerNum - 1));
        n   = s.len();
        bad = -1;
        // broken marker: cut short or one byte spoiled
        if (sel >= 40) begin
          if ($urandom_range(1)) n = $urandom_range(1, n - 1);
          else bad = $urandom_range(0, n - 1);
        end
        for (int i = 0; i < n; i++) begin
          c = ByteW'(s[i]);
          if (verdict_board::lower(c) >= 8'h61 && verdict_board::lower(c) <= 8'h7a &&
              $urandom_range(1)) begin
            c = c ^ 8'h20;
          end
          if (i == bad) c = c ^ ByteW'($urandom_range(1, 255));
          msg.push_back(c);
        end
      end else if (sel < 60) begin
        msg.push_back('0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          msg.push_back($urandom_range(1) ? ByteW'($urandom_range(32, 126))
                                          : ByteW'($urandom_range(1, 255)));
        end
      end
    end
  endfunction

  task automatic run_phase(int s_idle, int r_idle, logic [MinW-1:0] thr);
    logic [ByteW-1:0] msg [$];
    int sent;
    wait_drained();
    write_threshold(thr);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    sent     = 0;
    while (sent < PhaseItems) begin
      compose_message(msg);
      send_message(msg);
      sent += msg.size();
    end
  endtask

  initial begin
    logic [ByteW-1:0] msg [$];
    string mk;
    board        = new();
    snd_idle     = 19;
    rcv_idle     = 67;
    hold_span    = 0;
    quiet_cycles = 0;
    rst_n             <= 1'b0;
    item_if.valid     <= 1'b0;
    item_if.text_byte <= '0;
    item_if.last_byte <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.min_points <= '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero on the last byte, extremes, case edges, text cut by zero
    msg = '{8'h00};
    send_message(msg);
    msg = '{8'hff};
    send_message(msg);
    msg = '{8'h41, 8'h5a, 8'h61, 8'h7a, 8'h40, 8'h5b, 8'h60, 8'h7b};
    send_message(msg);
    msg = '{8'h80, 8'h00, 8'h7f, 8'h01};
    send_message(msg);
    msg = '{8'h55, 8'haa};
    send_message(msg);

    // every marker in one message, then one hidden behind a zero byte
    msg.delete();
    for (int m = 0; m < MarkerNum; m++) begin
      mk = verdict_board::marker_text(m);
      for (int i = 0; i < mk.len(); i++) msg.push_back(ByteW'(mk.getc(i)));
    end
    send_message(msg);
    msg.delete();
    msg.push_back('0);
    mk = verdict_board::marker_text(2);
    for (int i = 0; i < mk.len(); i++) msg.push_back(ByteW'(mk.getc(i)));
    send_message(msg);

    run_phase(19, 67, 3'd0);
    run_phase(19, 67, 3'd4);
    run_phase(67, 19, 3'd7);
    run_phase(67, 19, 3'd1);
    run_phase(0, 0, 3'd5);

    // result side holds off while short messages keep coming
    wait_drained();
    hold_span = 200;
    repeat (40) begin
      msg.delete();
      repeat ($urandom_range(1, 3)) msg.push_back(ByteW'($urandom_range(32, 126)));
      send_message(msg);
    end
    run_phase(0, 0, 3'd2);

    wait_drained();
    repeat (10) @(negedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
